FILE: rtl/core/wpg_pkg.sv
// Shared types and constants for the WAV PCM gain-to-stereo block.
// Used by the channel interfaces, the gain stage, the result queue and the top level.
package wpg_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FORMAT      = 3'd0,
        KIND_FRAME       = 3'd1,
        KIND_BAD_HEADER  = 3'd2,
        KIND_UNSUPPORTED = 3'd3,
        KIND_END         = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [31:0]        rate_hz;
        logic [15:0]        channel_count;
        logic [15:0]        sample_bits;
    } result_t;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [5:0]  POS_FMT_LAST   = 6'd19;
    localparam logic [5:0]  POS_SCAN_START = 6'd20;
    localparam logic [5:0]  POS_HDR_LAST   = 6'd43;
    localparam logic [5:0]  HDR_BYTES      = 6'd44;

    localparam logic [31:0] FMT_MIN_LEN    = 32'd16;
    localparam logic [15:0] GAIN_UNITY     = 16'h1000;

    // Bytes per frame for the supported forms; zero marks an unsupported form
    localparam logic [2:0]  FRAME_NONE     = 3'd0;
    localparam logic [2:0]  FRAME_MONO8    = 3'd1;
    localparam logic [2:0]  FRAME_MONO16   = 3'd2;
    localparam logic [2:0]  FRAME_STEREO16 = 3'd4;

    localparam logic signed [20:0] SAMPLE_MAX = 21'sd32767;
    localparam logic signed [20:0] SAMPLE_MIN = -21'sd32768;

    // Byte i of a four-character tag, first character first
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] i);
        return tag[{~i, 3'b000} +: 8];
    endfunction

    function automatic result_t make_result(input kind_t k);
        result_t r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

endpackage

FILE: rtl/core/wpg_if.sv
// Valid/ready channel interfaces: file bytes in, results out, gain register writes.
// Depends on wpg_pkg for the result kind type.
interface wpg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       stream_end;

    modport source (output valid, output file_byte, output stream_end, input ready);
    modport sink   (input valid, input file_byte, input stream_end, output ready);
endinterface

interface wpg_out_if;
    import wpg_pkg::*;
    logic               valid;
    logic               ready;
    kind_t              kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_count;
    logic [15:0]        sample_bits;

    modport source (output valid, output kind, output left_sample, output right_sample,
                    output rate_hz, output channel_count, output sample_bits, input ready);
    modport sink   (input valid, input kind, input left_sample, input right_sample,
                    input rate_hz, input channel_count, input sample_bits, output ready);
endinterface

interface wpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] gain_q4_12;

    modport source (output valid, output gain_q4_12, input ready);
    modport sink   (input valid, input gain_q4_12, output ready);
endinterface

FILE: rtl/core/wpg_gain.sv
// Q4.12 gain on a pair of 16-bit samples: truncate toward zero, saturate to 16 bits.
// Depends on wpg_pkg for the saturation limits.
module wpg_gain (
    input  logic [15:0]        gain,
    input  logic signed [15:0] raw_left,
    input  logic signed [15:0] raw_right,
    output logic signed [15:0] out_left,
    output logic signed [15:0] out_right
);
    import wpg_pkg::*;

    function automatic logic signed [15:0] apply_gain(input logic signed [15:0] s,
                                                      input logic [15:0] g);
        logic signed [32:0] prod;
        logic signed [32:0] biased;
        logic signed [20:0] q;
        prod   = s * $signed({1'b0, g});
        // bias negative products so the shift rounds toward zero
        biased = prod + (prod[32] ? 33'sd4095 : 33'sd0);
        q      = biased[32:12];
        if (q > SAMPLE_MAX) begin
            return 16'sh7FFF;
        end
        else if (q < SAMPLE_MIN) begin
            return 16'sh8000;
        end
        else begin
            return q[15:0];
        end
    endfunction

    assign out_left  = apply_gain(raw_left, gain);
    assign out_right = apply_gain(raw_right, gain);

endmodule

FILE: rtl/core/wpg_outq.sv
// Small result queue: takes up to two words per cycle, hands out one while the pcm sink is ready.
// Depends on wpg_pkg (result_t) and wpg_if (wpg_out_if).
module wpg_outq #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  wpg_pkg::result_t  push_word [2],
    output logic              room,
    wpg_out_if.source         pcm
);
    import wpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W-1:0]   tail_next;
    logic [PTR_W-1:0]   tail_plus1;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop        = pcm.valid && pcm.ready;
    assign tail_plus1 = bump(tail_reg);
    // leave space for the two words one byte can produce
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        head_next  = pop ? bump(head_reg) : head_reg;
        tail_next  = tail_reg;
        if (push_count == 2'd1)
        begin
            tail_next = tail_plus1;
        end
        else if (push_count == 2'd2)
        begin
            tail_next = bump(tail_plus1);
        end
        count_next = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[tail_reg] <= push_word[0];
        end
        if (push_count == 2'd2)
        begin
            entry_reg[tail_plus1] <= push_word[1];
        end
    end

    assign pcm.valid         = (count_reg != '0);
    assign pcm.kind          = entry_reg[head_reg].kind;
    assign pcm.left_sample   = entry_reg[head_reg].left_sample;
    assign pcm.right_sample  = entry_reg[head_reg].right_sample;
    assign pcm.rate_hz       = entry_reg[head_reg].rate_hz;
    assign pcm.channel_count = entry_reg[head_reg].channel_count;
    assign pcm.sample_bits   = entry_reg[head_reg].sample_bits;

endmodule

FILE: rtl/core/wav_pcm_gain_to_stereo.sv
// Top level: byte-serial RIFF/WAVE parser with gained stereo PCM output.
// Depends on wpg_pkg, wpg_if, wpg_gain and wpg_outq.
//
//   channel | dir | word                                   | accepted when
//   --------+-----+----------------------------------------+--------------------
//   cfg     | in  | gain_q4_12                             | valid && ready
//   wav     | in  | file_byte, stream_end                  | valid && ready
//   pcm     | out | kind, left/right_sample, rate_hz,      | valid && ready
//           |     | channel_count, sample_bits             |
//
// One file byte per cycle while the queue has room: a byte sits in the input register
// while the parser and gain logic compute its zero to two results, which land in the
// result queue. A result is written into the queue as its byte leaves the input register
// and is offered on pcm from there, after passing the input register and a queue entry.
// The input register only advances while the queue has space for two words, so a stalled
// pcm sink holds wav.ready low after the queue fills; a byte with two results costs one
// extra queue slot. Reset clears the parser to the header phase and the gain to 1.0;
// no clearing pass is needed.
module wav_pcm_gain_to_stereo #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    wpg_cfg_if.sink    cfg,
    wpg_in_if.sink     wav,
    wpg_out_if.source  pcm
);
    import wpg_pkg::*;

    // configuration
    logic [15:0]        gain_reg;

    // input register
    logic               stage_valid_reg;
    logic [7:0]         stage_byte_reg;
    logic               stage_end_reg;
    logic               room;
    logic               fire;

    // parser state
    phase_t             phase_reg,        phase_next;
    logic [5:0]         pos_reg,          pos_next;
    logic               header_ok_reg,    header_ok_next;
    logic [31:0]        fmt_len_reg,      fmt_len_next;
    logic [15:0]        hdr_channels_reg, hdr_channels_next;
    logic [15:0]        hdr_bits_reg,     hdr_bits_next;
    logic [31:0]        hdr_rate_reg,     hdr_rate_next;
    logic [31:0]        chunk_tag_reg,    chunk_tag_next;
    logic [31:0]        chunk_len_reg,    chunk_len_next;
    logic [31:0]        skip_reg,         skip_next;
    logic               pad_reg,          pad_next;
    logic [2:0]         tag_cnt_reg,      tag_cnt_next;
    logic [31:0]        remain_reg,       remain_next;
    logic [23:0]        frame_bytes_reg,  frame_bytes_next;
    logic [1:0]         frame_idx_reg,    frame_idx_next;

    logic [2:0]         frame_len;
    logic signed [15:0] raw_left;
    logic signed [15:0] raw_right;
    logic signed [15:0] gained_left;
    logic signed [15:0] gained_right;

    result_t            res [2];
    logic [1:0]         res_count;
    logic [1:0]         push_count;

    logic [31:0]        tag_work;
    logic [31:0]        len_work;
    logic [31:0]        remain_work;
    logic [7:0]         b;

    assign cfg.ready = 1'b1;
    assign fire      = stage_valid_reg && room;
    assign wav.ready = !stage_valid_reg || room;
    assign b         = stage_byte_reg;

    always_comb
    begin
        if (hdr_bits_reg == 16'd16 && hdr_channels_reg == 16'd2)
        begin
            frame_len = FRAME_STEREO16;
        end
        else if (hdr_bits_reg == 16'd16 && hdr_channels_reg == 16'd1)
        begin
            frame_len = FRAME_MONO16;
        end
        else if (hdr_bits_reg == 16'd8 && hdr_channels_reg == 16'd1)
        begin
            frame_len = FRAME_MONO8;
        end
        else
        begin
            frame_len = FRAME_NONE;
        end
    end

    always_comb
    begin
        raw_left  = {b, frame_bytes_reg[7:0]};
        raw_right = raw_left;
        if (frame_len == FRAME_STEREO16)
        begin
            raw_left  = frame_bytes_reg[15:0];
            raw_right = {b, frame_bytes_reg[23:16]};
        end
        else if (frame_len == FRAME_MONO8)
        begin
            // unsigned byte minus 128, moved to the top byte
            raw_left  = {~b[7], b[6:0], 8'h00};
            raw_right = raw_left;
        end
    end

    wpg_gain u_gain (
        .gain      (gain_reg),
        .raw_left  (raw_left),
        .raw_right (raw_right),
        .out_left  (gained_left),
        .out_right (gained_right)
    );

    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        header_ok_next    = header_ok_reg;
        fmt_len_next      = fmt_len_reg;
        hdr_channels_next = hdr_channels_reg;
        hdr_bits_next     = hdr_bits_reg;
        hdr_rate_next     = hdr_rate_reg;
        chunk_tag_next    = chunk_tag_reg;
        chunk_len_next    = chunk_len_reg;
        skip_next         = skip_reg;
        pad_next          = pad_reg;
        tag_cnt_next      = tag_cnt_reg;
        remain_next       = remain_reg;
        frame_bytes_next  = frame_bytes_reg;
        frame_idx_next    = frame_idx_reg;
        tag_work          = chunk_tag_reg;
        len_work          = chunk_len_reg;
        remain_work       = remain_reg - 32'd1;
        res[0]            = '0;
        res[1]            = '0;
        res_count         = 2'd0;

        case (phase_reg)
            PH_HEADER:
            begin
                case (pos_reg) inside
                    [6'd0:6'd3]:
                    begin
                        if (b != tag_byte(TAG_RIFF, pos_reg[1:0]))
                        begin
                            header_ok_next = 1'b0;
                        end
                    end
                    [6'd8:6'd11]:
                    begin
                        if (b != tag_byte(TAG_WAVE, pos_reg[1:0]))
                        begin
                            header_ok_next = 1'b0;
                        end
                    end
                    [6'd16:6'd19]: fmt_len_next[{pos_reg[1:0], 3'b000} +: 8]      = b;
                    [6'd22:6'd23]: hdr_channels_next[{pos_reg[0], 3'b000} +: 8]   = b;
                    [6'd24:6'd27]: hdr_rate_next[{pos_reg[1:0], 3'b000} +: 8]     = b;
                    [6'd34:6'd35]: hdr_bits_next[{pos_reg[0], 3'b000} +: 8]       = b;
                    default: ;
                endcase

                if (pos_reg == POS_FMT_LAST)
                begin
                    if (fmt_len_next < FMT_MIN_LEN)
                    begin
                        res[res_count[0]] = make_result(KIND_BAD_HEADER);
                        res_count         = res_count + 2'd1;
                        phase_next        = PH_DONE;
                    end
                    else
                    begin
                        skip_next = fmt_len_next;
                    end
                end
                else if (pos_reg == POS_HDR_LAST && !header_ok_reg)
                begin
                    res[res_count[0]] = make_result(KIND_BAD_HEADER);
                    res_count         = res_count + 2'd1;
                    phase_next        = PH_DONE;
                end

                // chunk scan: skip body, drop pad, then collect tag and length
                if (phase_next == PH_HEADER && pos_reg >= POS_SCAN_START)
                begin
                    if (skip_reg != 32'd0)
                    begin
                        skip_next = skip_reg - 32'd1;
                    end
                    else if (pad_reg)
                    begin
                        pad_next = 1'b0;
                    end
                    else
                    begin
                        if (!tag_cnt_reg[2])
                        begin
                            tag_work = {chunk_tag_reg[23:0], b};
                        end
                        else
                        begin
                            len_work[{tag_cnt_reg[1:0], 3'b000} +: 8] = b;
                        end
                        chunk_tag_next = tag_work;
                        chunk_len_next = len_work;
                        if (tag_cnt_reg == 3'd7)
                        begin
                            tag_cnt_next = 3'd0;
                            if (tag_work == TAG_DATA)
                            begin
                                res[res_count[0]]               = make_result(KIND_FORMAT);
                                res[res_count[0]].rate_hz       = hdr_rate_reg;
                                res[res_count[0]].channel_count = hdr_channels_reg;
                                res[res_count[0]].sample_bits   = hdr_bits_reg;
                                res_count                       = res_count + 2'd1;
                                if (frame_len == FRAME_NONE)
                                begin
                                    res[res_count[0]] = make_result(KIND_UNSUPPORTED);
                                    res_count         = res_count + 2'd1;
                                    phase_next        = PH_DONE;
                                end
                                else
                                begin
                                    remain_next      = len_work;
                                    frame_bytes_next = '0;
                                    frame_idx_next   = '0;
                                    if (len_work == 32'd0)
                                    begin
                                        res[res_count[0]] = make_result(KIND_END);
                                        res_count         = res_count + 2'd1;
                                        phase_next        = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_DATA;
                                    end
                                end
                            end
                            else
                            begin
                                skip_next      = len_work;
                                pad_next       = len_work[0];
                                chunk_tag_next = '0;
                                chunk_len_next = '0;
                            end
                        end
                        else
                        begin
                            tag_cnt_next = tag_cnt_reg + 3'd1;
                        end
                    end
                end

                if (pos_reg != HDR_BYTES)
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end

            PH_DATA:
            begin
                remain_next = remain_work;
                if ({1'b0, frame_idx_reg} + 3'd1 < frame_len)
                begin
                    frame_bytes_next[{frame_idx_reg, 3'b000} +: 8] = b;
                    frame_idx_next = frame_idx_reg + 2'd1;
                end
                else
                begin
                    res[res_count[0]]              = make_result(KIND_FRAME);
                    res[res_count[0]].left_sample  = gained_left;
                    res[res_count[0]].right_sample = gained_right;
                    res_count                      = res_count + 2'd1;
                    frame_bytes_next               = '0;
                    frame_idx_next                 = '0;
                end
                if (remain_work == 32'd0)
                begin
                    res[res_count[0]] = make_result(KIND_END);
                    res_count         = res_count + 2'd1;
                    phase_next        = PH_DONE;
                end
            end

            default: ;
        endcase

        if (stage_end_reg)
        begin
            if (phase_next == PH_HEADER)
            begin
                res[res_count[0]] = make_result(KIND_BAD_HEADER);
                res_count         = res_count + 2'd1;
            end
            else if (phase_next == PH_DATA)
            begin
                res[res_count[0]] = make_result(KIND_END);
                res_count         = res_count + 2'd1;
            end
            // rearm for the next file
            phase_next        = PH_HEADER;
            pos_next          = '0;
            header_ok_next    = 1'b1;
            fmt_len_next      = '0;
            hdr_channels_next = '0;
            hdr_bits_next     = '0;
            hdr_rate_next     = '0;
            chunk_tag_next    = '0;
            chunk_len_next    = '0;
            skip_next         = '0;
            pad_next          = 1'b0;
            tag_cnt_next      = '0;
            remain_next       = '0;
            frame_bytes_next  = '0;
            frame_idx_next    = '0;
        end
    end

    assign push_count = fire ? res_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= GAIN_UNITY;
            stage_valid_reg  <= 1'b0;
            phase_reg        <= PH_HEADER;
            pos_reg          <= '0;
            header_ok_reg    <= 1'b1;
            fmt_len_reg      <= '0;
            hdr_channels_reg <= '0;
            hdr_bits_reg     <= '0;
            hdr_rate_reg     <= '0;
            chunk_tag_reg    <= '0;
            chunk_len_reg    <= '0;
            skip_reg         <= '0;
            pad_reg          <= 1'b0;
            tag_cnt_reg      <= '0;
            remain_reg       <= '0;
            frame_bytes_reg  <= '0;
            frame_idx_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                gain_reg <= cfg.gain_q4_12;
            end
            if (wav.ready)
            begin
                stage_valid_reg <= wav.valid;
            end
            if (fire)
            begin
                phase_reg        <= phase_next;
                pos_reg          <= pos_next;
                header_ok_reg    <= header_ok_next;
                fmt_len_reg      <= fmt_len_next;
                hdr_channels_reg <= hdr_channels_next;
                hdr_bits_reg     <= hdr_bits_next;
                hdr_rate_reg     <= hdr_rate_next;
                chunk_tag_reg    <= chunk_tag_next;
                chunk_len_reg    <= chunk_len_next;
                skip_reg         <= skip_next;
                pad_reg          <= pad_next;
                tag_cnt_reg      <= tag_cnt_next;
                remain_reg       <= remain_next;
                frame_bytes_reg  <= frame_bytes_next;
                frame_idx_reg    <= frame_idx_next;
            end
        end
    end

    // input word payload
    always_ff @(posedge clk)
    begin
        if (wav.valid && wav.ready)
        begin
            stage_byte_reg <= wav.file_byte;
            stage_end_reg  <= wav.stream_end;
        end
    end

    wpg_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_word  (res),
        .room       (room),
        .pcm        (pcm)
    );

endmodule

FILE: test/wav_pcm_gain_to_stereo_test.sv
// Self-checking testbench for wav_pcm_gain_to_stereo: drives whole WAV files byte by byte,
// predicts every pcm word with a scoreboard class and compares them field by field.
// Depends on wpg_pkg, the wpg channel interfaces and the top level of the block.
`timescale 1ns / 1ps

import wpg_pkg::*;

class pcm_result_board;
    result_t     pending_pcm[$];
    int unsigned mismatches;
    logic [15:0] gain;

    phase_t      parse_phase;
    logic [31:0] byte_pos;
    logic [15:0] hdr_channels;
    logic [15:0] hdr_bits;
    logic [31:0] hdr_rate;
    logic [31:0] fmt_len;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_len;
    logic [31:0] skip_left;
    logic [31:0] data_left;
    logic [23:0] frame_acc;
    int          frame_idx;
    int          tag_idx;
    bit          header_ok;
    bit          pad_due;

    function new();
        mismatches = 0;
        gain       = GAIN_UNITY;
        rearm();
    endfunction

    function void rearm();
        parse_phase  = PH_HEADER;
        byte_pos     = '0;
        hdr_channels = '0;
        hdr_bits     = '0;
        hdr_rate     = '0;
        fmt_len      = '0;
        chunk_tag    = '0;
        chunk_len    = '0;
        skip_left    = '0;
        data_left    = '0;
        frame_acc    = '0;
        frame_idx    = 0;
        tag_idx      = 0;
        header_ok    = 1'b1;
        pad_due      = 1'b0;
    endfunction

    function void push(kind_t k, logic [15:0] l = '0, logic [15:0] r = '0,
                       logic [31:0] rate = '0, logic [15:0] ch = '0, logic [15:0] bits = '0);
        result_t w;
        w               = '0;
        w.kind          = k;
        w.left_sample   = l;
        w.right_sample  = r;
        w.rate_hz       = rate;
        w.channel_count = ch;
        w.sample_bits   = bits;
        pending_pcm.push_back(w);
    endfunction

    function logic [2:0] bytes_per_frame();
        if (hdr_bits == 16 && hdr_channels == 2) return FRAME_STEREO16;
        if (hdr_bits == 16 && hdr_channels == 1) return FRAME_MONO16;
        if (hdr_bits == 8 && hdr_channels == 1) return FRAME_MONO8;
        return FRAME_NONE;
    endfunction

    // Q4.12 multiply, truncate toward zero, clamp to 16 bits
    function logic [15:0] apply_gain(int s);
        longint p;
        longint q;
        p = longint'(s) * longint'(gain);
        if (p < 0) q = -((-p) / 4096);
        else q = p / 4096;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function int le16(logic [7:0] lo, logic [7:0] hi);
        int v;
        v = $signed({hi, lo});
        return v;
    endfunction

    function void capture(logic [31:0] pos, logic [7:0] b);
        if (pos < 4) begin
            if (b != TAG_RIFF[8 * (3 - pos) +: 8]) header_ok = 1'b0;
        end else if (pos >= 8 && pos < 12) begin
            if (b != TAG_WAVE[8 * (11 - pos) +: 8]) header_ok = 1'b0;
        end else if (pos >= 16 && pos < 20) begin
            fmt_len = fmt_len | ({24'd0, b} << (8 * (pos - 16)));
        end else if (pos >= 22 && pos < 24) begin
            hdr_channels = hdr_channels | ({8'd0, b} << (8 * (pos - 22)));
        end else if (pos >= 24 && pos < 28) begin
            hdr_rate = hdr_rate | ({24'd0, b} << (8 * (pos - 24)));
        end else if (pos >= 34 && pos < 36) begin
            hdr_bits = hdr_bits | ({8'd0, b} << (8 * (pos - 34)));
        end
    endfunction

    // True when this byte completes the header of the data chunk
    function bit scan(logic [7:0] b);
        if (skip_left != 0) begin
            skip_left--;
            return 1'b0;
        end
        if (pad_due) begin
            pad_due = 1'b0;
            return 1'b0;
        end
        if (tag_idx < 4) chunk_tag = {chunk_tag[23:0], b};
        else chunk_len = chunk_len | ({24'd0, b} << (8 * (tag_idx - 4)));
        tag_idx++;
        if (tag_idx < 8) return 1'b0;
        tag_idx = 0;
        if (chunk_tag == TAG_DATA) return 1'b1;
        skip_left = chunk_len;
        pad_due   = chunk_len[0];
        chunk_tag = '0;
        chunk_len = '0;
        return 1'b0;
    endfunction

    function void data_byte(logic [7:0] b);
        logic [2:0]  fs;
        logic [15:0] l;
        logic [15:0] r;
        fs = bytes_per_frame();
        data_left--;
        if (frame_idx + 1 < fs) begin
            frame_acc = frame_acc | ({16'd0, b} << (8 * frame_idx));
            frame_idx++;
        end else begin
            if (fs == FRAME_STEREO16) begin
                l = apply_gain(le16(frame_acc[7:0], frame_acc[15:8]));
                r = apply_gain(le16(frame_acc[23:16], b));
            end else if (fs == FRAME_MONO16) begin
                l = apply_gain(le16(frame_acc[7:0], b));
                r = l;
            end else begin
                l = apply_gain((int'(b) - 128) * 256);
                r = l;
            end
            push(KIND_FRAME, l, r);
            frame_acc = '0;
            frame_idx = 0;
        end
        if (data_left == 0) begin
            push(KIND_END);
            parse_phase = PH_DONE;
        end
    endfunction

    function void take_byte(logic [7:0] b, bit last);
        logic [31:0] pos;
        pos = byte_pos;
        if (parse_phase == PH_HEADER) begin
            if (pos < HDR_BYTES) capture(pos, b);
            if (pos == POS_FMT_LAST) begin
                if (fmt_len < FMT_MIN_LEN) begin
                    push(KIND_BAD_HEADER);
                    parse_phase = PH_DONE;
                end else begin
                    skip_left = fmt_len;
                end
            end else if (pos == POS_HDR_LAST && !header_ok) begin
                push(KIND_BAD_HEADER);
                parse_phase = PH_DONE;
            end
            if (parse_phase == PH_HEADER && pos >= POS_SCAN_START) begin
                if (scan(b)) begin
                    push(KIND_FORMAT, '0, '0, hdr_rate, hdr_channels, hdr_bits);
                    if (bytes_per_frame() == FRAME_NONE) begin
                        push(KIND_UNSUPPORTED);
                        parse_phase = PH_DONE;
                    end else begin
                        data_left = chunk_len;
                        frame_acc = '0;
                        frame_idx = 0;
                        if (data_left == 0) begin
                            push(KIND_END);
                            parse_phase = PH_DONE;
                        end else begin
                            parse_phase = PH_DATA;
                        end
                    end
                end
            end
            if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
        end else if (parse_phase == PH_DATA) begin
            data_byte(b);
        end
        if (last) begin
            if (parse_phase == PH_HEADER) push(KIND_BAD_HEADER);
            else if (parse_phase == PH_DATA) push(KIND_END);
            rearm();
        end
    endfunction

    function void check_word(kind_t k, logic signed [15:0] l, logic signed [15:0] r,
                             logic [31:0] rate, logic [15:0] ch, logic [15:0] bits);
        result_t w;
        if (pending_pcm.size() == 0) begin
            $error("unexpected pcm word: kind %0d", k);
            mismatches++;
            return;
        end
        w = pending_pcm.pop_front();
        if (k !== w.kind) begin
            $error("kind: expected %0d, got %0d", w.kind, k);
            mismatches++;
        end
        if (l !== w.left_sample) begin
            $error("left_sample: expected %0d, got %0d", w.left_sample, l);
            mismatches++;
        end
        if (r !== w.right_sample) begin
            $error("right_sample: expected %0d, got %0d", w.right_sample, r);
            mismatches++;
        end
        if (rate !== w.rate_hz) begin
            $error("rate_hz: expected %0d, got %0d", w.rate_hz, rate);
            mismatches++;
        end
        if (ch !== w.channel_count) begin
            $error("channel_count: expected %0d, got %0d", w.channel_count, ch);
            mismatches++;
        end
        if (bits !== w.sample_bits) begin
            $error("sample_bits: expected %0d, got %0d", w.sample_bits, bits);
            mismatches++;
        end
    endfunction
endclass

module wav_pcm_gain_to_stereo_test;

    localparam int CLK_PERIOD  = 4;
    localparam int BYTE_TARGET = 1975;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam logic [31:0] TAG_FMT = 32'h666d7420;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_RIFF,
        SHAPE_BAD_WAVE,
        SHAPE_SHORT_FMT,
        SHAPE_UNSUPPORTED,
        SHAPE_EMPTY_DATA,
        SHAPE_TRUNCATED,
        SHAPE_NOISE
    } shape_e;

    logic clk = 1'b0;
    logic rst_n;

    wpg_cfg_if cfg_ch ();
    wpg_in_if  wav_ch ();
    wpg_out_if pcm_ch ();

    wav_pcm_gain_to_stereo u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .wav   (wav_ch),
        .pcm   (pcm_ch)
    );

    pcm_result_board board = new();

    logic [7:0] wav_file[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         bytes_sent     = 0;
    int         quiet_cycles   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Sink side of the pcm channel
    initial begin
        pcm_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            pcm_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (cfg_ch.valid && cfg_ch.ready) begin
                board.gain   = cfg_ch.gain_q4_12;
                quiet_cycles = 0;
            end
            if (wav_ch.valid && wav_ch.ready) begin
                board.take_byte(wav_ch.file_byte, wav_ch.stream_end);
                quiet_cycles = 0;
            end
            if (pcm_ch.valid && pcm_ch.ready) begin
                board.check_word(pcm_ch.kind, pcm_ch.left_sample, pcm_ch.right_sample,
                                 pcm_ch.rate_hz, pcm_ch.channel_count, pcm_ch.sample_bits);
                quiet_cycles = 0;
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("wav_pcm_gain_to_stereo_test: errors");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            wav_ch.valid <= 1'b0;
            @(posedge clk);
        end
        wav_ch.valid      <= 1'b1;
        wav_ch.file_byte  <= b;
        wav_ch.stream_end <= last;
        @(posedge clk);
        while (!wav_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < wav_file.size(); i++) push_byte(wav_file[i], i == wav_file.size() - 1);
    endtask

    // Drain the block, let it settle, then write the gain word
    task automatic write_gain(input logic [15:0] g);
        wav_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_pcm.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.gain_q4_12 <= g;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) wav_file.push_back(v[8 * i +: 8]);
    endtask

    task automatic put_tag(input logic [31:0] v);
        for (int i = 0; i < 4; i++) wav_file.push_back(v[8 * (3 - i) +: 8]);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++) wav_file.push_back(8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] sample_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_file(input shape_e shape);
        int          fs;
        int          nbytes;
        int          fmt_len;
        int          clen;
        int          n_extra;
        logic [15:0] ch;
        logic [15:0] bits;
        logic [31:0] tag;
        logic [31:0] dlen;
        wav_file.delete();
        if (shape == SHAPE_NOISE) begin
            put_noise($urandom_range(1, 60));
            return;
        end
        case ($urandom_range(2))
            0: begin ch = 16'd2; bits = 16'd16; fs = 4; end
            1: begin ch = 16'd1; bits = 16'd16; fs = 2; end
            default: begin ch = 16'd1; bits = 16'd8; fs = 1; end
        endcase
        if (shape == SHAPE_UNSUPPORTED) begin
            fs = 1;
            case ($urandom_range(3))
                0: begin ch = 16'($urandom); bits = 16'($urandom); end
                1: begin ch = 16'd2; bits = 16'd8; end
                2: begin ch = 16'd0; bits = 16'd16; end
                default: begin ch = 16'd1; bits = 16'd24; end
            endcase
        end
        if (shape == SHAPE_SHORT_FMT) fmt_len = $urandom_range(15);
        else if ($urandom_range(3) == 0) fmt_len = 16 + $urandom_range(1, 9);
        else fmt_len = 16;

        put_tag(shape == SHAPE_BAD_RIFF ? TAG_RIFF ^ (32'd1 << $urandom_range(31)) : TAG_RIFF);
        put_le($urandom, 4);
        put_tag(shape == SHAPE_BAD_WAVE ? TAG_WAVE ^ (32'd1 << $urandom_range(31)) : TAG_WAVE);
        put_tag(TAG_FMT);
        put_le(fmt_len, 4);
        if (shape == SHAPE_SHORT_FMT) begin
            put_noise($urandom_range(30));
            return;
        end
        put_le(32'd1, 2);
        put_le(ch, 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(bits, 2);
        put_noise(fmt_len - 16);

        // Chunks to skip, odd sizes followed by a pad byte
        n_extra = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
        for (int k = 0; k < n_extra; k++) begin
            tag = $urandom;
            if (tag == TAG_DATA) tag = tag ^ 32'd1;
            clen = $urandom_range(7);
            put_tag(tag);
            put_le(clen, 4);
            put_noise(clen + (clen % 2));
        end

        nbytes = (shape == SHAPE_EMPTY_DATA) ? 0 : fs * $urandom_range(1, 12);
        if (shape != SHAPE_EMPTY_DATA && $urandom_range(3) == 0) nbytes += $urandom_range(fs - 1);
        dlen = nbytes;
        if (shape == SHAPE_TRUNCATED && $urandom_range(1) == 1) dlen = $urandom;
        put_tag(TAG_DATA);
        put_le(dlen, 4);
        for (int k = 0; k < nbytes; k++) wav_file.push_back(sample_byte());
        if ($urandom_range(3) == 0) put_noise($urandom_range(1, 5));
        if (shape == SHAPE_TRUNCATED) begin
            clen = $urandom_range(1, wav_file.size() - 1);
            while (wav_file.size() > clen) void'(wav_file.pop_back());
        end
    endtask

    function automatic shape_e pick_shape(input int file_no);
        int r;
        if (file_no <= SHAPE_TRUNCATED) return shape_e'(file_no);
        r = $urandom_range(99);
        if (r < 60) return SHAPE_GOOD;
        if (r < 66) return SHAPE_BAD_RIFF;
        if (r < 72) return SHAPE_BAD_WAVE;
        if (r < 78) return SHAPE_SHORT_FMT;
        if (r < 84) return SHAPE_UNSUPPORTED;
        if (r < 90) return SHAPE_EMPTY_DATA;
        if (r < 95) return SHAPE_TRUNCATED;
        return SHAPE_NOISE;
    endfunction

    initial begin
        int          file_no;
        int          phase_no;
        logic [15:0] g;
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.gain_q4_12 <= '0;
        wav_ch.valid      <= 1'b0;
        wav_ch.file_byte  <= '0;
        wav_ch.stream_end <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a one-byte file, then a fmt size under 16 followed by ignored bytes
        wav_file.delete();
        wav_file.push_back(8'hFF);
        send_file();
        wav_file.delete();
        put_tag(TAG_RIFF);
        put_le(32'hFFFF_FFFF, 4);
        put_tag(TAG_WAVE);
        put_tag(TAG_FMT);
        put_le(32'd0, 4);
        wav_file.push_back(8'h00);
        wav_file.push_back(8'hFF);
        send_file();

        file_no  = 0;
        phase_no = 0;
        while (bytes_sent < BYTE_TARGET) begin
            // The first phase runs on the reset gain
            if (phase_no > 0) begin
                case (phase_no)
                    1: g = 16'h0000;
                    2: g = 16'hFFFF;
                    3: g = GAIN_UNITY;
                    4: g = 16'h0001;
                    5: g = 16'h8000;
                    default: g = ($urandom_range(3) == 0) ? 16'($urandom_range(2048, 8192))
                                                          : 16'($urandom_range(65535));
                endcase
                write_gain(g);
            end
            case (phase_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int k = 0; k < 2; k++) begin
                build_file(pick_shape(file_no));
                send_file();
                file_no++;
            end
            phase_no++;
        end

        wav_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_pcm.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending_pcm.size() == 0) begin
            $display("wav_pcm_gain_to_stereo_test: clean");
        end else begin
            $display("wav_pcm_gain_to_stereo_test: errors");
        end
        $finish;
    end

endmodule

FILE: wav_pcm_gain_to_stereo.f
rtl/core/wpg_pkg.sv
rtl/core/wpg_if.sv
rtl/core/wpg_gain.sv
rtl/core/wpg_outq.sv
rtl/core/wav_pcm_gain_to_stereo.sv
test/wav_pcm_gain_to_stereo_test.sv
